// ===== sv/modexp_pkg.sv =====
// Package: modulus constants and the request/response types of the modular multiplier.
`timescale 1ns / 1ps
`default_nettype none
package modexp_pkg;

  // Operand and result width of the modular multiplier (the prime is below 2^30).
  localparam int unsigned ModW = 30;

  // The fixed prime modulus.
  localparam logic [ModW-1:0] Prime = 30'd1000000007;

  // Barrett constant: floor(2^60 / Prime), fits in 31 bits.
  localparam logic [63:0] MuWide = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] Mu     = MuWide[30:0];

  // Upper bound of the remainder before the final corrections (3 * Prime).
  localparam logic [31:0] Prime3 = 32'd3000000021;

  // Request into the modular multiplier.
  typedef struct packed {
    logic            start;
    logic [ModW-1:0] a;
    logic [ModW-1:0] b;
  } mm_req_t;

  // Response from the modular multiplier; done is a one-cycle pulse.
  typedef struct packed {
    logic            done;
    logic [ModW-1:0] prod;
  } mm_rsp_t;

endpackage
`default_nettype wire

// ===== sv/modexp_mulmod.sv =====
// Multi-cycle modular multiplier: one shared multiplier with Barrett reduction.
`timescale 1ns / 1ps
`default_nettype none
module modexp_mulmod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  modexp_pkg::mm_req_t req_i,
  output modexp_pkg::mm_rsp_t rsp_o
);
  import modexp_pkg::*;

  typedef enum logic [2:0] {
    MM_IDLE,
    MM_QEST,
    MM_BACK,
    MM_FIX1,
    MM_FIX2
  } mm_state_e;

  mm_state_e       state_q;
  logic [59:0]     prod_q;   // full product a*b
  logic [30:0]     quot_q;   // Barrett quotient estimate
  logic [31:0]     rem_q;    // remainder, below 3*Prime
  logic [ModW-1:0] res_q;
  logic            done_q;

  logic [30:0] op_a;
  logic [30:0] op_b;
  logic [61:0] mul_w;
  logic [31:0] rem_fix;

  // Operand select for the single multiplier
  always_comb begin
    case (state_q)
      MM_IDLE: begin
        op_a = {1'b0, req_i.a};
        op_b = {1'b0, req_i.b};
      end
      MM_QEST: begin
        op_a = prod_q[59:29];
        op_b = Mu;
      end
      MM_BACK: begin
        op_a = quot_q;
        op_b = {1'b0, Prime};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_w   = op_a * op_b;
  assign rem_fix = (rem_q >= {2'b0, Prime}) ? (rem_q - {2'b0, Prime}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MM_IDLE: begin
          if (req_i.start) begin
            state_q <= MM_QEST;
          end
        end
        MM_QEST: state_q <= MM_BACK;
        MM_BACK: state_q <= MM_FIX1;
        MM_FIX1: state_q <= MM_FIX2;
        MM_FIX2: begin
          state_q <= MM_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= MM_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      MM_IDLE: begin
        if (req_i.start) begin
          prod_q <= mul_w[59:0];
        end
      end
      MM_QEST: quot_q <= mul_w[61:31];
      // remainder < 2^32, so the low 32 bits are exact
      MM_BACK: rem_q  <= prod_q[31:0] - mul_w[31:0];
      MM_FIX1: rem_q  <= rem_fix;
      MM_FIX2: res_q  <= rem_fix[ModW-1:0];
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = res_q;

  // Barrett estimate leaves at most two corrections
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == MM_BACK |=> rem_q < Prime3)
    else $error("mulmod: remainder out of correction range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> res_q < Prime)
    else $error("mulmod: result not reduced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == MM_FIX2 |=> done_q && state_q == MM_IDLE)
    else $error("mulmod: missing done pulse");

endmodule
`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
// Top level: square-and-multiply modular exponentiation modulo 1000000007.
//
// Computes base^exponent mod 1000000007 for one transaction at a time. The
// base is first reduced by repeated subtraction (at most two subtractions),
// then the exponent is scanned LSB first over min(EXPONENT_BITS, 31) bits.
// Each bit costs one modular squaring and, on a set bit, one modular
// multiply beforehand; both run on a single shared Barrett multiplier. A
// finished result waits in S_DONE until any earlier result has left the
// output register. The next transaction can be accepted in the same cycle
// that the result appears. s_axis_tready is high only while no item is in
// work; a finished result sits in the output register, so the next
// transaction is accepted while the result is still waiting on
// m_axis_tready. A zero exponent yields 1, including for a zero base.
`timescale 1ns / 1ps
`default_nettype none
module modular_exponentiation #(
  parameter int unsigned EXPONENT_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [30:0] base, [61:31] exponent, [63:62] zero
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [29:0] power_mod, [31:30] zero
);
  import modexp_pkg::*;

  // Exponent field is 31 bits wide; higher scan positions never hold a set bit
  // and cannot change the result.
  localparam int unsigned ScanBits = (EXPONENT_BITS < 31) ? EXPONENT_BITS : 31;
  localparam int unsigned CntW     = $clog2(ScanBits + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_BIT,
    S_WMUL,
    S_WSQ,
    S_DONE
  } state_e;

  state_e          state_q;
  logic [30:0]     run_q;    // running base; 31 bits only while reducing
  logic [30:0]     exp_q;    // exponent, shifted right per bit
  logic [ModW-1:0] acc_q;    // accumulator
  logic [CntW-1:0] cnt_q;    // bit position
  logic            out_valid_q;
  logic [ModW-1:0] out_q;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic in_fire;
  logic out_free;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  modexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  // Multiplier requests: acc*run on a set bit, then run*run
  always_comb begin
    mm_req.start = 1'b0;
    mm_req.a     = run_q[ModW-1:0];
    mm_req.b     = run_q[ModW-1:0];
    case (state_q)
      S_BIT: begin
        mm_req.start = 1'b1;
        if (exp_q[0]) begin
          mm_req.a = acc_q;
        end
      end
      S_WMUL: mm_req.start = mm_rsp.done;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_REDUCE;
            cnt_q   <= '0;
          end
        end
        S_REDUCE: begin
          // base < 2^31 < 3*Prime: at most two subtractions
          if (run_q < {1'b0, Prime}) begin
            state_q <= S_BIT;
          end
        end
        S_BIT: begin
          state_q <= exp_q[0] ? S_WMUL : S_WSQ;
        end
        S_WMUL: begin
          if (mm_rsp.done) begin
            state_q <= S_WSQ;
          end
        end
        S_WSQ: begin
          if (mm_rsp.done) begin
            if (cnt_q == CntW'(ScanBits - 1)) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_BIT;
              cnt_q   <= cnt_q + CntW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          run_q <= s_axis_tdata[30:0];
          exp_q <= s_axis_tdata[61:31];
          acc_q <= ModW'(1);
        end
      end
      S_REDUCE: begin
        if (run_q >= {1'b0, Prime}) begin
          run_q <= run_q - {1'b0, Prime};
        end
      end
      S_WMUL: begin
        if (mm_rsp.done) begin
          acc_q <= mm_rsp.prod;
        end
      end
      S_WSQ: begin
        if (mm_rsp.done) begin
          run_q <= {1'b0, mm_rsp.prod};
          exp_q <= {1'b0, exp_q[30:1]};
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_q <= acc_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  // A response only arrives while the sequencer waits for one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.done |-> (state_q == S_WMUL || state_q == S_WSQ))
    else $error("modexp: unexpected multiplier response");

  // Delivered results are fully reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ModW-1:0] < Prime)
    else $error("modexp: result not reduced");

  // An accepted transaction goes straight to base reduction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_REDUCE)
    else $error("modexp: accept did not start the sequence");

  // Running base is reduced before any multiply is issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_req.start |-> run_q < {1'b0, Prime})
    else $error("modexp: multiply issued on unreduced base");

endmodule
`default_nettype wire
